@@ sv/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // Widths fixed by the register map
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned WORD_W = 64;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_REPL_BYTES     = 2'd2,
        CFG_REPL_LENGTH    = 2'd3
    } cfg_reg_t;

    // Per-cell window control
    typedef struct packed {
        logic shift;      // take neighbor's byte
        logic write_new;  // take the incoming byte
    } cell_ctl_t;

    // Load request into the output burst register
    typedef struct packed {
        logic load;
        len_t len;
        logic last;
        logic char_valid;
    } burst_load_t;

endpackage

`default_nettype wire

@@ sv/sfr_cell.sv @@
// ----------------------------------------------------------------------------
// sfr_cell
// One window position: holds a byte, forms the candidate byte for its slot
// and compares it with its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cell (
    input  wire logic              clk,
    input  wire sfr_pkg::cell_ctl_t ctl,
    input  wire logic              held,
    input  wire sfr_pkg::byte_t    in_char,
    input  wire sfr_pkg::byte_t    nbr_byte,
    input  wire sfr_pkg::byte_t    pat_byte,
    output sfr_pkg::byte_t         buf_byte,
    output logic                   eq
);

    sfr_pkg::byte_t win_reg;
    sfr_pkg::byte_t win_next;

    // slot at the fill point sees the incoming byte
    assign buf_byte = held ? win_reg : in_char;
    assign eq       = (buf_byte == pat_byte);

    always_comb
    begin
        win_next = win_reg;
        if (ctl.shift)
        begin
            win_next = nbr_byte;
        end
        else if (ctl.write_new)
        begin
            win_next = in_char;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

@@ sv/sfr_burst.sv @@
// ----------------------------------------------------------------------------
// sfr_burst
// Output burst register: a row of byte slots loaded in parallel and shifted
// out one beat per cycle toward slot 0 while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_burst #(
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sfr_pkg::burst_load_t            ld,
    input  wire logic [DEPTH-1:0][sfr_pkg::BYTE_W-1:0] ld_bytes,
    output logic                                 busy_one,
    output logic                                 idle,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output sfr_pkg::byte_t                       out_char,
    output logic                                 char_valid,
    output logic                                 out_last
);

    logic [DEPTH-1:0][sfr_pkg::BYTE_W-1:0] bytes_reg;
    logic [DEPTH-1:0][sfr_pkg::BYTE_W-1:0] bytes_next;
    sfr_pkg::len_t cnt_reg;
    sfr_pkg::len_t cnt_next;
    logic          last_reg;
    logic          last_next;
    logic          cv_reg;
    logic          cv_next;
    logic          pop;

    assign idle       = (cnt_reg == '0);
    assign busy_one   = (cnt_reg == sfr_pkg::len_t'(1));
    assign out_valid  = !idle;
    assign pop        = out_valid && out_ready;
    assign out_char   = cv_reg ? bytes_reg[0] : '0;
    assign char_valid = cv_reg;
    assign out_last   = last_reg && busy_one;

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        cv_next    = cv_reg;
        if (ld.load)
        begin
            bytes_next = ld_bytes;
            cnt_next   = ld.len;
            last_next  = ld.last;
            cv_next    = ld.char_valid;
        end
        else if (pop)
        begin
            for (int k = 0; k < DEPTH - 1; k++)
            begin
                bytes_next[k] = bytes_reg[k+1];
            end
            cnt_next = cnt_reg - sfr_pkg::len_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            last_reg <= 1'b0;
            cv_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            cv_reg   <= cv_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/stream_find_replace_top.sv @@
// ----------------------------------------------------------------------------
// stream_find_replace_top
// Streaming find-and-replace over a byte string.
// ----------------------------------------------------------------------------
// Takes one text byte per beat and replaces each leftmost, non-overlapping
// occurrence of the configured pattern with the replacement. While out_ready
// is high, a byte giving at most one output byte is taken every cycle and the
// burst register feeding the single output port drains one byte per cycle. A
// beat giving N bytes (a replacement, or an end-of-string flush) stalls input
// until that register holds its last byte. If the last byte gives no output,
// one beat with char_valid low carries out_last. Writing the pattern length
// drops any bytes held in the window. Configure only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace_top #(
    parameter int unsigned MAX_PATTERN     = 8,
    parameter int unsigned MAX_REPLACEMENT = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_char,
    input  wire logic        in_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_char,
    output logic             char_valid,
    output logic             out_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int unsigned BURST = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                    MAX_PATTERN : MAX_REPLACEMENT;
    localparam int unsigned CW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // config registers
    logic [sfr_pkg::WORD_W-1:0] pat_bytes_reg;
    logic [sfr_pkg::WORD_W-1:0] pat_bytes_next;
    sfr_pkg::len_t              pat_len_reg;
    sfr_pkg::len_t              pat_len_next;
    logic [sfr_pkg::WORD_W-1:0] rep_bytes_reg;
    logic [sfr_pkg::WORD_W-1:0] rep_bytes_next;
    sfr_pkg::len_t              rep_len_reg;
    sfr_pkg::len_t              rep_len_next;

    logic [CW-1:0] win_count_reg;
    logic [CW-1:0] win_count_next;

    logic          cfg_wr;
    logic          cfg_plen_wr;
    logic          take;
    sfr_pkg::len_t plen;
    sfr_pkg::len_t rlen;
    sfr_pkg::len_t cnt_ext;
    logic          full;
    logic          match;
    logic          burst_idle;
    logic          burst_one;
    sfr_pkg::len_t emit_len;

    sfr_pkg::cell_ctl_t cell_ctl [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] held;
    logic [MAX_PATTERN-1:0] eq;
    sfr_pkg::byte_t         buf_byte [MAX_PATTERN];

    sfr_pkg::burst_load_t                  ld;
    logic [BURST-1:0][sfr_pkg::BYTE_W-1:0] ld_bytes;

    assign cfg_ready   = 1'b1;
    assign cfg_wr      = cfg_valid && cfg_ready;
    assign cfg_plen_wr = cfg_wr &&
                         (sfr_pkg::cfg_reg_t'(cfg_index) == sfr_pkg::CFG_PATTERN_LENGTH);

    always_comb
    begin
        pat_bytes_next = pat_bytes_reg;
        pat_len_next   = pat_len_reg;
        rep_bytes_next = rep_bytes_reg;
        rep_len_next   = rep_len_reg;
        if (cfg_wr)
        begin
            unique case (sfr_pkg::cfg_reg_t'(cfg_index))
                sfr_pkg::CFG_PATTERN_BYTES:  pat_bytes_next = cfg_data;
                sfr_pkg::CFG_PATTERN_LENGTH: pat_len_next   = cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::CFG_REPL_BYTES:     rep_bytes_next = cfg_data;
                sfr_pkg::CFG_REPL_LENGTH:    rep_len_next   = cfg_data[sfr_pkg::LEN_W-1:0];
                default:                     pat_bytes_next = pat_bytes_reg;
            endcase
        end
    end

    // effective lengths: pattern 1..MAX_PATTERN, replacement 0..MAX_REPLACEMENT
    always_comb
    begin
        if (pat_len_reg == '0)
            plen = sfr_pkg::len_t'(1);
        else if (pat_len_reg > sfr_pkg::len_t'(MAX_PATTERN))
            plen = sfr_pkg::len_t'(MAX_PATTERN);
        else
            plen = pat_len_reg;

        if (rep_len_reg > sfr_pkg::len_t'(MAX_REPLACEMENT))
            rlen = sfr_pkg::len_t'(MAX_REPLACEMENT);
        else
            rlen = rep_len_reg;
    end

    assign in_ready = burst_idle || (burst_one && out_ready);
    assign take     = in_valid && in_ready;
    assign cnt_ext  = sfr_pkg::len_t'(win_count_reg);
    assign full     = ((cnt_ext + sfr_pkg::len_t'(1)) == plen);

    // window cells
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        sfr_pkg::byte_t nbr;

        if (k < MAX_PATTERN - 1)
        begin : g_nbr
            assign nbr = buf_byte[k+1];
        end
        else
        begin : g_end
            assign nbr = '0;
        end

        assign held[k] = (sfr_pkg::len_t'(k) < cnt_ext);

        always_comb
        begin
            cell_ctl[k].shift     = take && full && !match && !in_last;
            cell_ctl[k].write_new = take && !full && !in_last &&
                                    (sfr_pkg::len_t'(k) == cnt_ext);
        end

        sfr_cell u_cell (
            .clk      (clk),
            .ctl      (cell_ctl[k]),
            .held     (held[k]),
            .in_char  (in_char),
            .nbr_byte (nbr),
            .pat_byte (pat_bytes_reg[sfr_pkg::BYTE_W*k +: sfr_pkg::BYTE_W]),
            .buf_byte (buf_byte[k]),
            .eq       (eq[k])
        );
    end

    always_comb
    begin
        match = full;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if ((sfr_pkg::len_t'(k) < plen) && !eq[k])
                match = 1'b0;
        end
    end

    always_comb
    begin
        win_count_next = win_count_reg;
        if (cfg_plen_wr)
            win_count_next = '0;
        else if (take)
        begin
            if (in_last || match)
                win_count_next = '0;
            else if (!full)
                win_count_next = CW'(cnt_ext + sfr_pkg::len_t'(1));
        end
    end

    // burst load
    always_comb
    begin
        if (match)
            emit_len = rlen;
        else if (in_last)
            emit_len = cnt_ext + sfr_pkg::len_t'(1);
        else if (full)
            emit_len = sfr_pkg::len_t'(1);
        else
            emit_len = '0;

        for (int j = 0; j < BURST; j++)
        begin
            if (match)
                ld_bytes[j] = rep_bytes_reg[sfr_pkg::BYTE_W*j +: sfr_pkg::BYTE_W];
            else if (j < MAX_PATTERN)
                ld_bytes[j] = buf_byte[j];
            else
                ld_bytes[j] = '0;
        end

        ld.load       = take && ((emit_len != '0) || in_last);
        ld.last       = in_last;
        // empty end marker when nothing else goes out
        ld.char_valid = (emit_len != '0);
        ld.len        = (emit_len == '0) ? sfr_pkg::len_t'(1) : emit_len;
    end

    sfr_burst #(
        .DEPTH (BURST)
    ) u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .ld         (ld),
        .ld_bytes   (ld_bytes),
        .busy_one   (burst_one),
        .idle       (burst_idle),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .char_valid (char_valid),
        .out_last   (out_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= sfr_pkg::len_t'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            win_count_reg <= '0;
        end
        else
        begin
            pat_bytes_reg <= pat_bytes_next;
            pat_len_reg   <= pat_len_next;
            rep_bytes_reg <= rep_bytes_next;
            rep_len_reg   <= rep_len_next;
            win_count_reg <= win_count_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_stream_find_replace_top.sv @@
// ----------------------------------------------------------------------------
// tb_stream_find_replace_top
// Self-checking bench for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
// Drives text bytes through the valid/ready input channel and programs the
// pattern and replacement registers between phases. A scoreboard keeps its own
// copy of the window and registers and predicts every output beat in order.
// A short directed pass covers register extremes, length saturation, the
// empty end marker, zero bytes and a pattern length write mid-string. The
// random pass builds strings from pattern pieces and noise under shifting
// idle profiles, with one long receiver stall that backs up the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stream_find_replace_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_PATTERN     = 8;
    localparam int unsigned MAX_REPLACEMENT = 8;
    localparam int unsigned SETTLE_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned ITEMS_PER_PHASE = 66;
    localparam int unsigned LONG_HOLD       = 400;

    typedef struct packed {
        sfr_pkg::byte_t chr;
        logic           chr_valid;
        logic           last;
    } sfr_beat_t;

    // Tracks window and register state, queues the beats each byte produces
    class replace_scoreboard;
        sfr_pkg::byte_t window [7];
        int unsigned    held;
        logic [63:0]    pat_word;
        sfr_pkg::len_t  pat_len;
        logic [63:0]    rep_word;
        sfr_pkg::len_t  rep_len;
        sfr_beat_t      due_beats [$];
        int unsigned    mismatches;

        function new();
            foreach (window[k])
                window[k] = '0;
            held       = 0;
            pat_word   = '0;
            pat_len    = sfr_pkg::len_t'(1);
            rep_word   = '0;
            rep_len    = '0;
            mismatches = 0;
        endfunction

        function int unsigned pattern_span();
            int unsigned n;
            n = pat_len;
            if (n == 0)
                n = 1;
            if (n > MAX_PATTERN)
                n = MAX_PATTERN;
            return n;
        endfunction

        function int unsigned pending();
            return due_beats.size();
        endfunction

        function void set_register(sfr_pkg::cfg_reg_t idx, logic [63:0] val);
            case (idx)
                sfr_pkg::CFG_PATTERN_BYTES:  pat_word = val;
                sfr_pkg::CFG_PATTERN_LENGTH:
                begin
                    pat_len = val[3:0];
                    held    = 0;
                end
                sfr_pkg::CFG_REPL_BYTES:     rep_word = val;
                sfr_pkg::CFG_REPL_LENGTH:    rep_len  = val[3:0];
                default: ;
            endcase
        endfunction

        function void predict_byte(sfr_pkg::byte_t ch, logic closes);
            sfr_pkg::byte_t cand [8];
            sfr_beat_t      burst [8];
            int unsigned    span;
            int unsigned    rspan;
            int unsigned    fill;
            int unsigned    n;
            int unsigned    k;
            logic           hit;
            span  = pattern_span();
            rspan = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len;
            fill  = (held > span - 1) ? span - 1 : held;
            n     = 0;
            for (k = 0; k < fill; k++)
                cand[k] = window[k];
            cand[fill] = ch;
            fill++;
            if (fill == span)
            begin
                hit = 1'b1;
                for (k = 0; k < span; k++)
                    if (cand[k] != pat_word[8*k +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (k = 0; k < rspan; k++)
                    begin
                        burst[n] = '{rep_word[8*k +: 8], 1'b1, 1'b0};
                        n++;
                    end
                    fill = 0;
                end
                else
                begin
                    burst[n] = '{cand[0], 1'b1, 1'b0};
                    n++;
                    for (k = 1; k < fill; k++)
                        cand[k-1] = cand[k];
                    fill--;
                end
            end
            if (closes)
            begin
                for (k = 0; k < fill; k++)
                begin
                    burst[n] = '{cand[k], 1'b1, 1'b0};
                    n++;
                end
                fill = 0;
                // nothing left to carry the mark: empty end beat
                if (n == 0)
                begin
                    burst[0] = '{8'h00, 1'b0, 1'b1};
                    n = 1;
                end
                else
                    burst[n-1].last = 1'b1;
            end
            for (k = 0; k < fill; k++)
                window[k] = cand[k];
            held = fill;
            for (k = 0; k < n; k++)
                due_beats.push_back(burst[k]);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_beat(sfr_pkg::byte_t ch, logic cv, logic last);
            sfr_beat_t want;
            if (due_beats.size() == 0)
                report_mismatch($sformatf("beat with nothing due: char %02h valid %0b last %0b",
                                          ch, cv, last));
            else
            begin
                want = due_beats.pop_front();
                if (ch !== want.chr)
                    report_mismatch($sformatf("out_char %02h, want %02h", ch, want.chr));
                if (cv !== want.chr_valid)
                    report_mismatch($sformatf("char_valid %0b, want %0b", cv, want.chr_valid));
                if (last !== want.last)
                    report_mismatch($sformatf("out_last %0b, want %0b (char %02h)",
                                              last, want.last, want.chr));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_char;
    logic        in_last;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        out_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    replace_scoreboard sb;
    sfr_pkg::byte_t    text_q [$];
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       hold_req      = 0;
    int unsigned       hold_left     = 0;
    int unsigned       cycle_count   = 0;

    stream_find_replace_top #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .char_valid (char_valid),
        .out_last   (out_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_stream_find_replace_top: done, errors");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Input beats feed the prediction before output beats are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.predict_byte(in_char, in_last);
            if (out_valid && out_ready)
                sb.check_beat(out_char, char_valid, out_last);
        end
    end

    task automatic send_byte(sfr_pkg::byte_t ch, logic closes);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_char  <= ch;
        in_last  <= closes;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_text(logic closes);
        int unsigned i;
        for (i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], closes && (i == text_q.size() - 1));
    endtask

    // Wait for every due beat, then let a byte still in the window settle
    task automatic settle();
        in_valid <= 1'b0;
        // the last accepted beat is predicted at the edge just passed
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write
    task automatic write_reg(sfr_pkg::cfg_reg_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, val);
    endtask

    task automatic configure(logic [63:0] pat, sfr_pkg::len_t plen,
                             logic [63:0] rep, sfr_pkg::len_t rlen);
        settle();
        write_reg(sfr_pkg::CFG_PATTERN_BYTES, pat);
        write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'(plen));
        write_reg(sfr_pkg::CFG_REPL_BYTES, rep);
        write_reg(sfr_pkg::CFG_REPL_LENGTH, 64'(rlen));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned    phase;
        int unsigned    k;
        int unsigned    pick;
        int unsigned    budget;
        int unsigned    run_len;
        int unsigned    span;
        sfr_pkg::byte_t alpha [3];
        logic [63:0]    pat;
        logic [63:0]    rep;
        sfr_pkg::len_t  plen;
        sfr_pkg::len_t  rlen;
        logic           closes;

        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_char   <= '0;
        in_last   <= 1'b0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= sfr_pkg::CFG_PATTERN_BYTES;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: single zero byte pattern, empty replacement.
        // Zero byte is deleted, leaving only the empty end beat.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        // All-ones words, both lengths above the maximum
        configure('1, sfr_pkg::len_t'(15), '1, sfr_pkg::len_t'(15));
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Pattern length zero acts as one; replaced by eight zero bytes
        configure(64'h0000_0000_0000_4241, sfr_pkg::len_t'(0), '0, sfr_pkg::len_t'(8));
        send_byte(8'h41, 1'b1);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b1);

        // Upper pattern bytes ignored; length rewrite mid-string drops the window
        configure(64'hDEAD_BEEF_CC43_4241, sfr_pkg::len_t'(3),
                  64'h0000_0000_0000_0078, sfr_pkg::len_t'(1));
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        settle();
        write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd3);
        cfg_valid <= 1'b0;
        send_byte(8'h43, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b1);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (k = 0; k < 3; k++)
                alpha[k] = sfr_pkg::byte_t'($urandom_range(0, 255));
            // mostly a small alphabet so partial and overlapping matches occur
            for (k = 0; k < 8; k++)
                pat[8*k +: 8] = ($urandom_range(0, 3) != 0) ?
                                alpha[$urandom_range(0, 2)] :
                                sfr_pkg::byte_t'($urandom_range(0, 255));
            pick = $urandom_range(0, 19);
            if (pick < 16)
                plen = sfr_pkg::len_t'(pick % 8 + 1);
            else if (pick < 18)
                plen = '0;
            else
                plen = sfr_pkg::len_t'($urandom_range(9, 15));
            rep  = {$urandom, $urandom};
            rlen = sfr_pkg::len_t'($urandom_range(0, 10));
            configure(pat, plen, rep, rlen);

            if (phase < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 80;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == RANDOM_PHASES - 1)
                hold_req = LONG_HOLD;

            span   = sb.pattern_span();
            budget = ITEMS_PER_PHASE;
            while (budget > 0)
            begin
                text_q.delete();
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                      : $urandom_range(1, 12);
                while (text_q.size() < run_len)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        for (k = 0; k < span; k++)
                            text_q.push_back(pat[8*k +: 8]);
                    else if (pick < 8)
                        text_q.push_back(pat[8*$urandom_range(0, span - 1) +: 8]);
                    else
                        text_q.push_back(sfr_pkg::byte_t'($urandom_range(0, 255)));
                end
                // a string cut off at the phase end leaves bytes for the next length write
                closes = !(text_q.size() >= budget && $urandom_range(0, 2) == 0);
                send_text(closes);
                budget = (text_q.size() >= budget) ? 0 : budget - text_q.size();
            end
        end

        settle();
        if (sb.mismatches == 0)
            $display("tb_stream_find_replace_top: done, clean");
        else
            $display("tb_stream_find_replace_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
